[sv/sfr_pkg.sv]
package sfr_pkg;

  localparam int SFR_MAX_PAYLOAD = 32;
  localparam int SFR_QUEUE_DEPTH = 4;

  localparam logic [7:0] SYNC_RESET = 8'hAA;
  localparam logic [7:0] CRC_POLY   = 8'h8C;

  // Parser phases of the receive side
  typedef enum logic [2:0] {
    PH_SYNC,
    PH_TYPE,
    PH_LEN,
    PH_DATA,
    PH_CRC
  } phase_t;

  // Pop sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_POP
  } pop_state_t;

  typedef struct packed {
    logic ld_type;    // take TYPE byte, fold into CRC
    logic ld_len;     // take LEN byte, fold into CRC, rewind position
    logic wr_data;    // write payload byte, fold into CRC, advance position
    logic push;       // commit the assembled frame to the queue
    logic clr_crc;    // restart the frame CRC
    logic pop_start;  // latch the oldest frame and retire it from the queue
    logic pop_issue;  // emit one result into the output register
  } cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic len_over;
    logic len_zero;
    logic data_last;
    logic crc_ok;
    logic pop_marker;
    logic pop_last;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[sv/sfr_ram.sv]
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/sfr_ctrl.sv]
module sfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  input  sfr_pkg::sts_t sts,
  output sfr_pkg::cmd_t cmd
);

  import sfr_pkg::*;

  phase_t     phase_r, phase_nxt;
  pop_state_t state_r, state_nxt;
  logic       rx_acc;
  logic       pop_acc;

  assign in_ready = (state_r == ST_IDLE);
  assign rx_acc   = in_valid && in_ready && !in_kind;
  assign pop_acc  = in_valid && in_ready && in_kind;

  // parser next phase
  always_comb begin
    phase_nxt = phase_r;
    if (rx_acc) begin
      unique case (phase_r)
        PH_SYNC: begin
          if (sts.sync_hit) phase_nxt = PH_TYPE;
        end
        PH_TYPE: phase_nxt = PH_LEN;
        PH_LEN: begin
          if (sts.len_over)      phase_nxt = PH_SYNC;
          else if (sts.len_zero) phase_nxt = PH_CRC;
          else                   phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          if (sts.data_last) phase_nxt = PH_CRC;
        end
        PH_CRC: phase_nxt = sts.sync_hit ? PH_TYPE : PH_SYNC;
        default: phase_nxt = PH_SYNC;
      endcase
    end
  end

  // pop sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_acc) state_nxt = ST_POP;
      end
      ST_POP: begin
        if (sts.out_free && (sts.pop_marker || sts.pop_last)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    if (rx_acc) begin
      unique case (phase_r)
        PH_SYNC: cmd.clr_crc = sts.sync_hit;
        PH_TYPE: cmd.ld_type = 1'b1;
        PH_LEN: begin
          cmd.ld_len  = !sts.len_over;
          cmd.clr_crc = sts.len_over;
        end
        PH_DATA: cmd.wr_data = 1'b1;
        PH_CRC: begin
          cmd.push    = sts.crc_ok;
          cmd.clr_crc = 1'b1;
        end
        default: cmd.clr_crc = 1'b1;
      endcase
    end
    cmd.pop_start = pop_acc;
    cmd.pop_issue = (state_r == ST_POP) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC;
      state_r <= ST_IDLE;
    end else begin
      phase_r <= phase_nxt;
      state_r <= state_nxt;
    end
  end

endmodule

[sv/sfr_dp.sv]
module sfr_dp #(
  parameter int MAX_PAYLOAD = sfr_pkg::SFR_MAX_PAYLOAD,
  parameter int QUEUE_DEPTH = sfr_pkg::SFR_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic [7:0]    in_rx_byte,
  input  logic          out_ready,
  input  sfr_pkg::cmd_t cmd,
  output sfr_pkg::sts_t sts,
  output logic          out_valid,
  output logic          out_frame_ready,
  output logic [7:0]    out_frame_type,
  output logic [5:0]    out_payload_len,
  output logic [7:0]    out_payload_byte,
  output logic          out_byte_valid,
  output logic          out_last
);

  import sfr_pkg::*;

  // one spare slot holds the frame under assembly, so a full queue is never
  // disturbed until the new frame passes its CRC
  localparam int NSLOT = QUEUE_DEPTH + 1;
  localparam int SW    = $clog2(NSLOT);
  localparam int LW    = $clog2(MAX_PAYLOAD + 1);
  localparam int PW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int DEPTH = NSLOT * MAX_PAYLOAD;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]    sync_r;
  logic [7:0]    crc_r, crc_nxt;
  logic [7:0]    type_r;
  logic [LW-1:0] len_r;
  logic [PW-1:0] pos_r;
  logic [LW-1:0] pos_inc;

  logic [SW-1:0] wslot_r, wslot_nxt;
  logic [SW-1:0] rslot_r, rslot_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic [7:0]    qtype_r [NSLOT];
  logic [LW-1:0] qlen_r  [NSLOT];

  logic [SW-1:0] pop_slot_r;
  logic [7:0]    pop_type_r;
  logic [LW-1:0] pop_len_r;
  logic [PW-1:0] pop_cnt_r;
  logic          pop_empty_r;

  logic          out_valid_r, out_valid_nxt;
  logic          frame_ready_r;
  logic [7:0]    frame_type_r;
  logic [5:0]    len_out_r;
  logic          bvalid_r;
  logic          last_r;

  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          re;
  logic [7:0]    rdata;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(NSLOT - 1)) ? '0 : s + SW'(1);
  endfunction

  assign pos_inc = LW'(pos_r) + LW'(1);

  always_comb begin
    sts            = '0;
    sts.sync_hit   = (in_rx_byte == sync_r);
    sts.len_over   = (in_rx_byte > 8'(MAX_PAYLOAD));
    sts.len_zero   = (in_rx_byte == 8'd0);
    sts.data_last  = (pos_inc >= len_r);
    sts.crc_ok     = (crc_r == in_rx_byte);
    sts.pop_marker = pop_empty_r || (pop_len_r == '0);
    sts.pop_last   = ((LW'(pop_cnt_r) + LW'(1)) == pop_len_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    crc_nxt = crc_r;
    if (cmd.clr_crc) begin
      crc_nxt = '0;
    end else if (cmd.ld_type || cmd.ld_len || cmd.wr_data) begin
      crc_nxt = crc8_byte(crc_r, in_rx_byte);
    end
  end

  // queue pointers; push and pop start never share a cycle
  always_comb begin
    wslot_nxt = wslot_r;
    rslot_nxt = rslot_r;
    held_nxt  = held_r;
    if (cmd.push) begin
      wslot_nxt = slot_inc(wslot_r);
      if (held_r == HW'(QUEUE_DEPTH)) begin
        rslot_nxt = slot_inc(rslot_r);
      end else begin
        held_nxt = held_r + HW'(1);
      end
    end else if (cmd.pop_start && (held_r != '0)) begin
      rslot_nxt = slot_inc(rslot_r);
      held_nxt  = held_r - HW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.pop_issue) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= SYNC_RESET;
      crc_r       <= '0;
      wslot_r     <= '0;
      rslot_r     <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) sync_r <= cfg_wr_data;
      crc_r       <= crc_nxt;
      wslot_r     <= wslot_nxt;
      rslot_r     <= rslot_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_type) type_r <= in_rx_byte;
    if (cmd.ld_len) begin
      len_r <= LW'(in_rx_byte);
      pos_r <= '0;
    end else if (cmd.wr_data) begin
      pos_r <= PW'(pos_inc);
    end
    if (cmd.push) begin
      qtype_r[wslot_r] <= type_r;
      qlen_r[wslot_r]  <= len_r;
    end
    if (cmd.pop_start) begin
      pop_empty_r <= (held_r == '0);
      pop_type_r  <= qtype_r[rslot_r];
      pop_len_r   <= qlen_r[rslot_r];
      pop_slot_r  <= rslot_r;
      pop_cnt_r   <= '0;
    end else if (cmd.pop_issue) begin
      pop_cnt_r <= pop_cnt_r + PW'(1);
    end
    if (cmd.pop_issue) begin
      frame_ready_r <= !pop_empty_r;
      frame_type_r  <= pop_empty_r ? 8'd0 : pop_type_r;
      len_out_r     <= sts.pop_marker ? 6'd0 : 6'(pop_len_r);
      bvalid_r      <= !sts.pop_marker;
      last_r        <= sts.pop_marker || sts.pop_last;
    end
  end

  assign waddr = AW'(AW'(wslot_r) * AW'(MAX_PAYLOAD) + AW'(pos_r));
  assign raddr = AW'(AW'(pop_slot_r) * AW'(MAX_PAYLOAD) + AW'(pop_cnt_r));
  assign re    = cmd.pop_issue && !sts.pop_marker;

  sfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (cmd.wr_data),
    .waddr (waddr),
    .wdata (in_rx_byte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_frame_ready  = frame_ready_r;
  assign out_frame_type   = frame_type_r;
  assign out_payload_len  = len_out_r;
  assign out_payload_byte = bvalid_r ? rdata : 8'd0;
  assign out_byte_valid   = bvalid_r;
  assign out_last         = last_r;

endmodule

[sv/sync_frame_receiver_crc8_unit.sv]
// Receive-side parser for framed messages SYNC, TYPE, LEN, PAYLOAD[LEN], CRC,
// with a queue of up to QUEUE_DEPTH good frames (oldest overwritten when full).
// Each input transaction is either one received line byte (in_kind = 0) or a
// pop request (in_kind = 1). A line byte gives no result; bytes can stream in
// back to back. The CRC is CRC-8, reflected polynomial 0x8C, initial value 0,
// over TYPE, LEN and the payload; a LEN above MAX_PAYLOAD drops the frame, and
// a CRC byte equal to the sync value (pass or fail) starts a new frame. A pop
// returns the oldest frame as one result per payload byte, or a single marker
// result for an empty queue or a zero-length frame, with out_last set on the
// final one. Taking a pop latches the frame, and the input is then held off
// until the final result has been issued; results come one per cycle out of
// the single read port of the payload RAM while the result side accepts them,
// and backpressure on the result side holds the input off for longer. The RAM
// holds QUEUE_DEPTH + 1 frame slots: the spare slot takes the frame under
// assembly so a full queue stays intact until the new frame passes its CRC.
// The memories need no clearing after reset. The sync value is written
// through cfg_wr_en / cfg_wr_data and resets to 0xAA.
module sync_frame_receiver_crc8_unit #(
  parameter int MAX_PAYLOAD = sfr_pkg::SFR_MAX_PAYLOAD,
  parameter int QUEUE_DEPTH = sfr_pkg::SFR_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_frame_ready,
  output logic [7:0] out_frame_type,
  output logic [5:0] out_payload_len,
  output logic [7:0] out_payload_byte,
  output logic       out_byte_valid,
  output logic       out_last
);

  import sfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: parser phases and pop sequencing
  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: CRC, frame assembly, queue, payload RAM and output register
  sfr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_rx_byte       (in_rx_byte),
    .out_ready        (out_ready),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_frame_ready  (out_frame_ready),
    .out_frame_type   (out_frame_type),
    .out_payload_len  (out_payload_len),
    .out_payload_byte (out_payload_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // Data results only come from a delivered frame
  a_data_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_frame_ready)
    else $error("payload byte flagged valid without a frame");

  // Empty-queue marker is a single cleared result
  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_ready |-> out_last && !out_byte_valid &&
      (out_frame_type == 8'd0) && (out_payload_len == 6'd0))
    else $error("empty marker malformed");

  // A pop holds off the input in the cycle after the pop request
  a_pop_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind |=> !in_ready)
    else $error("input taken right after a pop request");

  // Parser issues at most one of ld_type, ld_len, wr_data and push per byte
  a_one_parse_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ld_type, cmd.ld_len, cmd.wr_data, cmd.push}))
    else $error("conflicting parser commands");
`endif

endmodule
